[src/d8sd_pkg.sv]
// Shared types, constants and helper functions of the D8 flow direction core.
package d8sd_pkg;

   localparam int ELEV_BITS = 32;
   localparam int COL_BITS = 10;
   localparam int ROW_BITS = 12;
   localparam int WIDTH_BITS = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS = 4096;
   localparam int MIN_SIDE = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_BITS = 4;
   localparam int QUEUE_CNT_BITS = 5;
   localparam int DIAG_BITS = 16;
   localparam int DIAG_NUM = 46341;
   localparam int SLOT_BITS = 4;
   localparam int NUM_NEIGHBOURS = 8;
   localparam int WINDOW_CELLS = 9;
   localparam int CENTRE_SLOT = 4;

   // Window slot of each neighbour, in the order W, NW, N, NE, E, SE, S, SW.
   localparam logic [SLOT_BITS-1:0] NEIGHBOUR_SLOT [NUM_NEIGHBOURS] =
      '{4'd3, 4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_COLUMNS = 2'd0,
      CSR_GRID_ROWS    = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      DIR_W    = 4'd0,
      DIR_NW   = 4'd1,
      DIR_N    = 4'd2,
      DIR_NE   = 4'd3,
      DIR_E    = 4'd4,
      DIR_SE   = 4'd5,
      DIR_S    = 4'd6,
      DIR_SW   = 4'd7,
      DIR_NONE = 4'd8
   } dir_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  columns;
      logic [HEIGHT_BITS-1:0] rows;
      logic                   restart;
   } cfg_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      dir_type             dir;
      logic                frame_end;
   } job_type;

   typedef struct packed {
      logic has_data;
      logic full;
   } queue_status_type;

   function automatic logic [WIDTH_BITS-1:0] clamp_columns(input logic [WIDTH_BITS-1:0] raw);
      if (raw < WIDTH_BITS'(MIN_SIDE)) begin
         return WIDTH_BITS'(MIN_SIDE);
      end else if (raw > WIDTH_BITS'(MAX_COLUMNS)) begin
         return WIDTH_BITS'(MAX_COLUMNS);
      end
      return raw;
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] clamp_rows(input logic [HEIGHT_BITS-1:0] raw);
      if (raw < HEIGHT_BITS'(MIN_SIDE)) begin
         return HEIGHT_BITS'(MIN_SIDE);
      end else if (raw > HEIGHT_BITS'(MAX_ROWS)) begin
         return HEIGHT_BITS'(MAX_ROWS);
      end
      return raw;
   endfunction

   function automatic logic cell_inner(input logic [COL_BITS-1:0]    col,
                                       input logic [HEIGHT_BITS-1:0] row,
                                       input logic [WIDTH_BITS-1:0]  w,
                                       input logic [HEIGHT_BITS-1:0] h);
      logic [WIDTH_BITS:0]  col3;
      logic [HEIGHT_BITS:0] row3;
      col3 = (WIDTH_BITS+1)'(col) + (WIDTH_BITS+1)'(3);
      row3 = (HEIGHT_BITS+1)'(row) + (HEIGHT_BITS+1)'(3);
      return (col >= COL_BITS'(2)) && (col3 <= (WIDTH_BITS+1)'(w)) &&
             (row >= HEIGHT_BITS'(2)) && (row3 <= (HEIGHT_BITS+1)'(h));
   endfunction

   // A cell may be reported once it lies on the grid and, if interior, its
   // whole neighbourhood has arrived with the input at column x, row y.
   function automatic logic cell_emittable(input logic [COL_BITS-1:0]    col,
                                           input logic [HEIGHT_BITS-1:0] row,
                                           input logic [COL_BITS-1:0]    x,
                                           input logic [ROW_BITS-1:0]    y,
                                           input logic [WIDTH_BITS-1:0]  w,
                                           input logic [HEIGHT_BITS-1:0] h);
      logic [HEIGHT_BITS:0] row1;
      logic [HEIGHT_BITS:0] yy;
      logic [WIDTH_BITS-1:0] col1;
      logic [WIDTH_BITS-1:0] xx;
      logic                  ready;
      row1 = (HEIGHT_BITS+1)'(row) + (HEIGHT_BITS+1)'(1);
      yy = (HEIGHT_BITS+1)'(y);
      col1 = WIDTH_BITS'(col) + WIDTH_BITS'(1);
      xx = WIDTH_BITS'(x);
      ready = (yy > row1) || ((yy == row1) && (xx >= col1));
      return (row < h) && (!cell_inner(col, row, w, h) || ready);
   endfunction

   function automatic logic [ELEV_BITS-1:0] diag_slope(input logic [ELEV_BITS-1:0] mag);
      logic [ELEV_BITS+DIAG_BITS-1:0] prod;
      logic [DIAG_BITS-1:0]           k;
      k = DIAG_BITS'(DIAG_NUM);
      prod = (ELEV_BITS+DIAG_BITS)'(mag) * (ELEV_BITS+DIAG_BITS)'(k);
      return prod[ELEV_BITS+DIAG_BITS-1:DIAG_BITS];
   endfunction

endpackage

[src/d8_steepest_descent_direction_core.sv]
// Top level of the D8 steepest-descent direction core with its register port.
//
// Elevations (signed Q16.16) enter in raster order through a queue-like port:
// an item is transferred when req_push is high and req_full is low. Results
// leave through a second queue-like port: while rsp_empty is low the oldest
// result is on the rsp_ ports and it is transferred when rsp_pop is high.
// Each result carries the cell's column and row, its D8 direction (eight for
// no flow), a flag on the last result caused by one input and a flag on the
// final cell of the grid. Cells near the border are always no flow.
// The grid size is set through the csr_ write channel, which is always ready;
// a write to a grid register restarts the frame and is meant for an idle core.
// An input passes the input, window, sign and magnitude, slope and candidate
// registers and the queue on its way to the output register. The core takes
// one input per cycle while it has room; the sequencer handles each result,
// and each input that causes none, in turn while the output register is free;
// an input at a row end causes a burst of four results. A sixteen-entry queue
// absorbs these bursts, and req_full rises when sixteen inputs are in flight.
// When the receiver stalls, the queue fills and req_full holds off the source.
// Reset empties the core, sets the grid to 1024 by 4096 and restarts the frame.
module d8_steepest_descent_direction_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_push,
   output logic                                       req_full,
   input  logic signed [d8sd_pkg::ELEV_BITS-1:0]      req_elevation,
   output logic                                       rsp_empty,
   input  logic                                       rsp_pop,
   output logic [d8sd_pkg::COL_BITS-1:0]              rsp_cell_column,
   output logic [d8sd_pkg::ROW_BITS-1:0]              rsp_cell_row,
   output logic [3:0]                                 rsp_direction,
   output logic                                       rsp_last_of_run,
   output logic                                       rsp_frame_done,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [d8sd_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [d8sd_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import d8sd_pkg::*;

   logic [WIDTH_BITS-1:0]  columns_ff;
   logic [HEIGHT_BITS-1:0] rows_ff;
   logic                   csr_write;
   cfg_type                cfg;
   logic                   queue_push;
   logic                   queue_pop;
   job_type                queue_data;
   job_type                head;
   queue_status_type       q_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= WIDTH_BITS'(MAX_COLUMNS);
         rows_ff <= HEIGHT_BITS'(MAX_ROWS);
      end else if (csr_write) begin
         if (csr_index == CSR_GRID_COLUMNS) begin
            columns_ff <= csr_wdata[WIDTH_BITS-1:0];
         end else if (csr_index == CSR_GRID_ROWS) begin
            rows_ff <= csr_wdata[HEIGHT_BITS-1:0];
         end
      end
   end

   assign cfg.columns = clamp_columns(columns_ff);
   assign cfg.rows = clamp_rows(rows_ff);
   assign cfg.restart = csr_write &&
                        (csr_index == CSR_GRID_COLUMNS || csr_index == CSR_GRID_ROWS);

   d8sd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_elevation (req_elevation),
      .queue_push    (queue_push),
      .queue_data    (queue_data),
      .queue_pop     (queue_pop)
   );

   d8sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (queue_pop),
      .head      (head),
      .status    (q_status)
   );

   d8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head            (head),
      .head_valid      (q_status.has_data),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_direction   (rsp_direction),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !q_status.full || queue_pop)
      else $error("Slope pipeline pushed into a full queue.");

   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> rsp_last_of_run)
      else $error("Final result of the grid does not close its run.");

   a_border_no_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_cell_row < ROW_BITS'(2) || rsp_cell_column < COL_BITS'(2)))
      |-> (rsp_direction == DIR_NONE))
      else $error("Border cell was given a flow direction.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("Result held after reset.");
`endif

endmodule

[src/d8sd_front.sv]
// Front end: raster position, line buffers, 3x3 window and steepest slope pipeline.
module d8sd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  d8sd_pkg::cfg_type                     cfg,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [d8sd_pkg::ELEV_BITS-1:0] req_elevation,
   output logic                                  queue_push,
   output d8sd_pkg::job_type                     queue_data,
   input  logic                                  queue_pop
);
   import d8sd_pkg::*;

   logic                      accept;
   logic                      last_col;
   logic                      last_row;
   logic [COL_BITS-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [QUEUE_CNT_BITS-1:0] credits_ff, credits_in;

   logic [2*ELEV_BITS-1:0]    line_mem [MAX_COLUMNS];
   logic [2*ELEV_BITS-1:0]    rd_data_ff;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [ELEV_BITS-1:0]      s1_elev_ff;
   logic [COL_BITS-1:0]       s1_col_ff, s2_col_ff, s3_col_ff, s4_col_ff, s5_col_ff;
   logic [ROW_BITS-1:0]       s1_row_ff, s2_row_ff, s3_row_ff, s4_row_ff, s5_row_ff;
   logic                      s1_end_ff, s2_end_ff, s3_end_ff, s4_end_ff, s5_end_ff;

   logic [ELEV_BITS-1:0]      win_ff [WINDOW_CELLS];
   logic [ELEV_BITS:0]        diff [NUM_NEIGHBOURS];
   logic                      pos_ff [NUM_NEIGHBOURS];
   logic [ELEV_BITS-1:0]      mag_ff [NUM_NEIGHBOURS];
   logic [ELEV_BITS-1:0]      slope_ff [NUM_NEIGHBOURS];
   logic [ELEV_BITS-1:0]      cand_slope_ff [NUM_NEIGHBOURS/2];
   dir_type                   cand_dir_ff [NUM_NEIGHBOURS/2];

   logic [ELEV_BITS-1:0]      pair_a_slope, pair_b_slope, best_slope;
   dir_type                   pair_a_dir, pair_b_dir, best_dir;

   assign req_full = (credits_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign accept = req_push && !req_full;
   assign last_col = (WIDTH_BITS'(col_ff) == cfg.columns - WIDTH_BITS'(1));
   assign last_row = (HEIGHT_BITS'(row_ff) == cfg.rows - HEIGHT_BITS'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   assign credits_in = credits_ff + QUEUE_CNT_BITS'(accept) - QUEUE_CNT_BITS'(queue_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         credits_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         credits_ff <= credits_in;
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Line buffer: upper row in the high half, middle row in the low half.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[col_ff];
      end
      if (v1_ff) begin
         line_mem[s1_col_ff] <= {rd_data_ff[ELEV_BITS-1:0], s1_elev_ff};
      end
   end

   always_ff @(posedge clock) begin
      s1_elev_ff <= req_elevation;
      s1_col_ff <= col_ff;
      s1_row_ff <= row_ff;
      s1_end_ff <= last_col && last_row;
      s2_col_ff <= s1_col_ff;
      s2_row_ff <= s1_row_ff;
      s2_end_ff <= s1_end_ff;
      s3_col_ff <= s2_col_ff;
      s3_row_ff <= s2_row_ff;
      s3_end_ff <= s2_end_ff;
      s4_col_ff <= s3_col_ff;
      s4_row_ff <= s3_row_ff;
      s4_end_ff <= s3_end_ff;
      s5_col_ff <= s4_col_ff;
      s5_row_ff <= s4_row_ff;
      s5_end_ff <= s4_end_ff;
      if (v1_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rd_data_ff[2*ELEV_BITS-1:ELEV_BITS];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= rd_data_ff[ELEV_BITS-1:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_elev_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_NEIGHBOURS; i++) begin
         diff[i] = {win_ff[CENTRE_SLOT][ELEV_BITS-1], win_ff[CENTRE_SLOT]} -
                   {win_ff[NEIGHBOUR_SLOT[i]][ELEV_BITS-1], win_ff[NEIGHBOUR_SLOT[i]]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_NEIGHBOURS; i++) begin
         pos_ff[i] <= !diff[i][ELEV_BITS] && (diff[i] != '0);
         mag_ff[i] <= diff[i][ELEV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_NEIGHBOURS; i++) begin
         if (!pos_ff[i]) begin
            slope_ff[i] <= '0;
         end else if (i % 2 == 1) begin
            slope_ff[i] <= diag_slope(mag_ff[i]);
         end else begin
            slope_ff[i] <= mag_ff[i];
         end
      end
   end

   // The earlier direction keeps a tie; a later one wins only when strictly steeper.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_NEIGHBOURS/2; k++) begin
         if (slope_ff[2*k+1] > slope_ff[2*k]) begin
            cand_slope_ff[k] <= slope_ff[2*k+1];
            cand_dir_ff[k] <= dir_type'(4'(2*k+1));
         end else begin
            cand_slope_ff[k] <= slope_ff[2*k];
            cand_dir_ff[k] <= dir_type'(4'(2*k));
         end
      end
   end

   always_comb begin
      if (cand_slope_ff[1] > cand_slope_ff[0]) begin
         pair_a_slope = cand_slope_ff[1];
         pair_a_dir = cand_dir_ff[1];
      end else begin
         pair_a_slope = cand_slope_ff[0];
         pair_a_dir = cand_dir_ff[0];
      end
      if (cand_slope_ff[3] > cand_slope_ff[2]) begin
         pair_b_slope = cand_slope_ff[3];
         pair_b_dir = cand_dir_ff[3];
      end else begin
         pair_b_slope = cand_slope_ff[2];
         pair_b_dir = cand_dir_ff[2];
      end
      if (pair_b_slope > pair_a_slope) begin
         best_slope = pair_b_slope;
         best_dir = pair_b_dir;
      end else begin
         best_slope = pair_a_slope;
         best_dir = pair_a_dir;
      end
   end

   assign queue_push = v5_ff;
   assign queue_data.col = s5_col_ff;
   assign queue_data.row = s5_row_ff;
   assign queue_data.dir = (best_slope == '0) ? DIR_NONE : best_dir;
   assign queue_data.frame_end = s5_end_ff;

endmodule

[src/d8sd_queue.sv]
// Short queue that decouples the slope pipeline from the result sequencer.
module d8sd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  d8sd_pkg::job_type          push_data,
   input  logic                       pop,
   output d8sd_pkg::job_type          head,
   output d8sd_pkg::queue_status_type status
);
   import d8sd_pkg::*;

   job_type                   store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         count_ff <= count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = store_ff[rd_ptr_ff];
   assign status.has_data = (count_ff != '0);
   assign status.full = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));

endmodule

[src/d8sd_back.sv]
// Back end: walks the report position and issues results into the output register.
module d8sd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  d8sd_pkg::cfg_type                    cfg,
   input  d8sd_pkg::job_type                    head,
   input  logic                                 head_valid,
   output logic                                 queue_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [d8sd_pkg::COL_BITS-1:0]        rsp_cell_column,
   output logic [d8sd_pkg::ROW_BITS-1:0]        rsp_cell_row,
   output logic [3:0]                           rsp_direction,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_frame_done
);
   import d8sd_pkg::*;

   logic [COL_BITS-1:0]    rep_col_ff, rep_col_in;
   logic [HEIGHT_BITS-1:0] rep_row_ff, rep_row_in;
   logic [1:0]             run_ff, run_in;
   logic                   out_valid_ff;
   logic [COL_BITS-1:0]    out_col_ff;
   logic [ROW_BITS-1:0]    out_row_ff;
   dir_type                out_dir_ff;
   logic                   out_last_ff;
   logic                   out_done_ff;

   logic                   slot_free, step, emit_now, emit_next, last_run, finish, wrap;
   logic [WIDTH_BITS-1:0]  col_plus;
   logic [COL_BITS-1:0]    next_col;
   logic [HEIGHT_BITS-1:0] next_row;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign step = head_valid && slot_free;

   assign col_plus = WIDTH_BITS'(rep_col_ff) + WIDTH_BITS'(1);
   assign wrap = (col_plus >= cfg.columns);
   assign next_col = wrap ? '0 : col_plus[COL_BITS-1:0];
   assign next_row = wrap ? rep_row_ff + HEIGHT_BITS'(1) : rep_row_ff;

   assign emit_now = cell_emittable(rep_col_ff, rep_row_ff, head.col, head.row,
                                    cfg.columns, cfg.rows);
   assign emit_next = cell_emittable(next_col, next_row, head.col, head.row,
                                     cfg.columns, cfg.rows);
   assign last_run = (run_ff == 2'd3) || !emit_next;
   assign finish = !emit_now || last_run;
   assign queue_pop = step && finish;

   always_comb begin
      rep_col_in = rep_col_ff;
      rep_row_in = rep_row_ff;
      run_in = run_ff;
      if (cfg.restart) begin
         rep_col_in = '0;
         rep_row_in = '0;
         run_in = '0;
      end else if (step) begin
         if (finish) begin
            run_in = '0;
         end else begin
            run_in = run_ff + 2'd1;
         end
         if (finish && head.frame_end) begin
            rep_col_in = '0;
            rep_row_in = '0;
         end else if (emit_now) begin
            rep_col_in = next_col;
            rep_row_in = next_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_col_ff <= '0;
         rep_row_ff <= '0;
         run_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rep_col_ff <= rep_col_in;
         rep_row_ff <= rep_row_in;
         run_ff <= run_in;
         if (step && emit_now) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit_now) begin
         out_col_ff <= rep_col_ff;
         out_row_ff <= rep_row_ff[ROW_BITS-1:0];
         out_dir_ff <= cell_inner(rep_col_ff, rep_row_ff, cfg.columns, cfg.rows) ?
                       head.dir : DIR_NONE;
         out_last_ff <= last_run;
         out_done_ff <= (next_row >= cfg.rows);
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_cell_column = out_col_ff;
   assign rsp_cell_row = out_row_ff;
   assign rsp_direction = out_dir_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_frame_done = out_done_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the D8 steepest-descent direction core.
module tb;
   import d8sd_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_CYCLES = 300;
   localparam int REPORT_LINES = 40;
   localparam longint unsigned DIAG_SCALE = 46341;
   localparam int NEIGHBOUR_CELL [NUM_NEIGHBOURS] = '{3, 0, 1, 2, 5, 8, 7, 6};
   localparam int RING_DX [NUM_NEIGHBOURS] = '{-1, -1, 0, 1, 1, 1, 0, -1};
   localparam int RING_DY [NUM_NEIGHBOURS] = '{0, -1, -1, -1, 0, 1, 1, 1};

   typedef struct {
      logic [COL_BITS-1:0] column;
      logic [ROW_BITS-1:0] row;
      dir_type             direction;
      logic                last_of_run;
      logic                frame_done;
   } flow_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic signed [ELEV_BITS-1:0]      req_elevation = '0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [COL_BITS-1:0]              rsp_cell_column;
   logic [ROW_BITS-1:0]              rsp_cell_row;
   logic [3:0]                       rsp_direction;
   logic                             rsp_last_of_run;
   logic                             rsp_frame_done;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [CSR_INDEX_BITS-1:0]        csr_index = CSR_GRID_COLUMNS;
   logic [CSR_DATA_BITS-1:0]         csr_wdata = '0;

   logic                             stall_trigger = 1'b0;
   int                               stall_remaining = 0;
   int                               send_idle_pct = 0;
   int                               recv_idle_pct = 0;
   int                               mismatch_count = 0;

   logic [WIDTH_BITS-1:0]            grid_columns_raw;
   logic [HEIGHT_BITS-1:0]           grid_rows_raw;
   logic signed [ELEV_BITS-1:0]      upper_line [MAX_COLUMNS];
   logic signed [ELEV_BITS-1:0]      middle_line [MAX_COLUMNS];
   logic signed [ELEV_BITS-1:0]      window [WINDOW_CELLS];
   int unsigned                      in_col, in_row, out_col, out_row;
   flow_result_type                  pending_flows [$];

   d8_steepest_descent_direction_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_elevation   (req_elevation),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_direction   (rsp_direction),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned active_columns();
      if (grid_columns_raw < MIN_SIDE) return MIN_SIDE;
      if (grid_columns_raw > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(grid_columns_raw);
   endfunction

   function automatic int unsigned active_rows();
      if (grid_rows_raw < MIN_SIDE) return MIN_SIDE;
      if (grid_rows_raw > MAX_ROWS) return MAX_ROWS;
      return int'(grid_rows_raw);
   endfunction

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void reset_flow_model();
      int i;
      grid_columns_raw = WIDTH_BITS'(MAX_COLUMNS);
      grid_rows_raw = HEIGHT_BITS'(MAX_ROWS);
      for (i = 0; i < MAX_COLUMNS; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      for (i = 0; i < WINDOW_CELLS; i++) begin
         window[i] = '0;
      end
      restart_frame();
   endfunction

   function automatic longint unsigned diagonal_slope(input longint unsigned drop);
      return (drop >> 16) * DIAG_SCALE + (((drop & 64'hFFFF) * DIAG_SCALE) >> 16);
   endfunction

   function automatic dir_type steepest_direction();
      longint            drop;
      longint unsigned   slope;
      longint unsigned   best;
      dir_type           choice;
      int                i;
      best = 0;
      choice = DIR_NONE;
      for (i = 0; i < NUM_NEIGHBOURS; i++) begin
         drop = longint'(window[CENTRE_SLOT]) - longint'(window[NEIGHBOUR_CELL[i]]);
         if (drop > 0) begin
            slope = (i % 2 == 1) ? diagonal_slope(drop) : longint'(drop);
            if (slope > best) begin
               best = slope;
               choice = dir_type'(i);
            end
         end
      end
      return choice;
   endfunction

   function automatic void predict_flows(input logic signed [ELEV_BITS-1:0] elevation);
      int unsigned     w, h, x, y, cx, cy, n, r;
      logic            inner;
      logic            ready;
      flow_result_type flow;
      w = active_columns();
      h = active_rows();
      x = in_col;
      y = in_row;
      n = 0;
      if (x >= w || y >= h) begin
         restart_frame();
         x = 0;
         y = 0;
      end
      for (r = 0; r < 3; r++) begin
         window[r * 3] = window[r * 3 + 1];
         window[r * 3 + 1] = window[r * 3 + 2];
      end
      window[2] = upper_line[x];
      window[5] = middle_line[x];
      window[8] = elevation;
      upper_line[x] = middle_line[x];
      middle_line[x] = elevation;
      while (n < 4 && out_row < h) begin
         cx = out_col;
         cy = out_row;
         flow.direction = DIR_NONE;
         inner = cx >= 2 && cx + 3 <= w && cy >= 2 && cy + 3 <= h;
         if (inner) begin
            ready = (y > cy + 1) || (y == cy + 1 && x >= cx + 1);
            if (!ready) break;
            flow.direction = steepest_direction();
         end
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         flow.column = cx[COL_BITS-1:0];
         flow.row = cy[ROW_BITS-1:0];
         flow.last_of_run = 1'b0;
         flow.frame_done = out_row >= h;
         pending_flows.push_back(flow);
         n++;
      end
      if (n > 0) begin
         flow = pending_flows[$];
         flow.last_of_run = 1'b1;
         pending_flows[$] = flow;
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
      end
      if (y >= h) begin
         restart_frame();
      end else begin
         in_col = x;
         in_row = y;
      end
   endfunction

   task automatic report_mismatch(input string message);
      if (mismatch_count < REPORT_LINES) $display("ERROR at %0t: %s", $realtime, message);
      mismatch_count++;
   endtask

   task automatic check_flow_result();
      flow_result_type want;
      if (pending_flows.size() == 0) begin
         report_mismatch($sformatf("unexpected result for cell (%0d,%0d)",
                                   rsp_cell_column, rsp_cell_row));
      end else begin
         want = pending_flows.pop_front();
         if (rsp_cell_column !== want.column)
            report_mismatch($sformatf("cell_column %0d, expected %0d",
                                      rsp_cell_column, want.column));
         if (rsp_cell_row !== want.row)
            report_mismatch($sformatf("cell_row %0d, expected %0d", rsp_cell_row, want.row));
         if (rsp_direction !== 4'(want.direction))
            report_mismatch($sformatf("direction %0d, expected %0d at cell (%0d,%0d)",
                                      rsp_direction, want.direction, want.column, want.row));
         if (rsp_last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, expected %0b at cell (%0d,%0d)",
                                      rsp_last_of_run, want.last_of_run, want.column, want.row));
         if (rsp_frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %0b, expected %0b at cell (%0d,%0d)",
                                      rsp_frame_done, want.frame_done, want.column, want.row));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_flow_result();
         rsp_pop <= (stall_remaining == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_remaining <= 0;
      end else if (stall_trigger) begin
         stall_remaining <= STALL_CYCLES;
      end else if (stall_remaining > 0) begin
         stall_remaining <= stall_remaining - 1;
      end
   end

   function automatic logic signed [ELEV_BITS-1:0] random_elevation();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick < 4) return $urandom;
      if (pick < 11) return ELEV_BITS'(int'($urandom_range(0, 64)) - 32);
      if (pick < 14) return ELEV_BITS'(int'($urandom_range(0, 2_000_000)) - 1_000_000);
      if (pick == 14) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
   endfunction

   task automatic push_elevation(input logic signed [ELEV_BITS-1:0] elevation);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_elevation <= elevation;
      do @(posedge clock); while (req_full);
      predict_flows(elevation);
   endtask

   task automatic push_random_cells(input int count);
      repeat (count) push_elevation(random_elevation());
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (pending_flows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input logic [CSR_DATA_BITS-1:0] columns,
                           input logic [CSR_DATA_BITS-1:0] rows);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_GRID_COLUMNS;
      csr_wdata <= columns;
      do @(posedge clock); while (!csr_ready);
      grid_columns_raw = columns[WIDTH_BITS-1:0];
      restart_frame();
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows;
      do @(posedge clock); while (!csr_ready);
      grid_rows_raw = rows;
      restart_frame();
      csr_valid <= 1'b0;
   endtask

   // One 5 by 5 frame whose only interior cell sits at the centre of the given ring.
   task automatic send_window_frame(input logic signed [ELEV_BITS-1:0] centre,
                                    input logic signed [ELEV_BITS-1:0] cardinal,
                                    input logic signed [ELEV_BITS-1:0] diagonal,
                                    input dir_type first_dir,
                                    input logic signed [ELEV_BITS-1:0] first_value,
                                    input dir_type second_dir,
                                    input logic signed [ELEV_BITS-1:0] second_value);
      int                          x, y, k;
      logic signed [ELEV_BITS-1:0] value;
      for (y = 0; y < MIN_SIDE; y++) begin
         for (x = 0; x < MIN_SIDE; x++) begin
            value = $urandom;
            if (x == 2 && y == 2) value = centre;
            for (k = 0; k < NUM_NEIGHBOURS; k++) begin
               if (x == 2 + RING_DX[k] && y == 2 + RING_DY[k]) begin
                  if (dir_type'(k) == first_dir) value = first_value;
                  else if (dir_type'(k) == second_dir) value = second_value;
                  else value = (k % 2 == 1) ? diagonal : cardinal;
               end
            end
            push_elevation(value);
         end
      end
   endtask

   task automatic test_reset_grid();
      push_random_cells(8);
   endtask

   task automatic test_directed_windows();
      set_grid(13'h1805, 13'h0000);
      send_window_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                        DIR_NONE, 0, DIR_NONE, 0);
      send_window_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        DIR_NONE, 0, DIR_NONE, 0);
      send_window_frame(0, 0, 0, DIR_NONE, 0, DIR_NONE, 0);
      send_window_frame(100, 100, 99, DIR_NONE, 0, DIR_NONE, 0);
      send_window_frame(50, 50, 50, DIR_N, 10, DIR_E, 10);
      send_window_frame(32'sh30000, 32'sh30000, 32'sh30000, DIR_SW, 32'sh10000,
                        DIR_S, 32'sh20000);
   endtask

   task automatic test_clamped_grid();
      set_grid(13'h1FFF, 13'h1FFF);
      push_random_cells(8);
   endtask

   task automatic test_random_grids(input int item_budget);
      int sent, columns, rows, w, h, count;
      sent = 0;
      while (sent < item_budget) begin
         columns = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
         rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
         set_grid(CSR_DATA_BITS'(columns), CSR_DATA_BITS'(rows));
         w = (columns < MIN_SIDE) ? MIN_SIDE : columns;
         h = (rows < MIN_SIDE) ? MIN_SIDE : rows;
         count = w * h * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count + w);
         if (count > item_budget - sent) count = item_budget - sent;
         push_random_cells(count);
         sent += count;
      end
   endtask

   task automatic test_backpressure();
      set_grid(6, 6);
      stall_trigger <= 1'b1;
      @(posedge clock);
      stall_trigger <= 1'b0;
      push_random_cells(40);
   endtask

   initial begin
      reset_flow_model();
      send_idle_pct = 8;
      recv_idle_pct = 62;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_grid();
      test_directed_windows();
      test_clamped_grid();
      test_random_grids(20);
      send_idle_pct = 62;
      recv_idle_pct = 8;
      test_random_grids(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_grids(20);
      test_backpressure();
      settle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
